/* hw/rtl/gtsp_pkg.sv */
// Shared constants and types for the GPS telemetry slot packer.
`default_nettype none

package gtsp_pkg;

    // Number of telemetry slots; a word is valid only strictly inside 0..SLOT_COUNT.
    localparam int SLOT_COUNT = 32;

    // Register map, selected by paddr[2].
    localparam logic REG_BASE_SLOT = 1'b0;
    localparam logic [4:0] BASE_SLOT_RESET = 5'd1;

    // floor(2^32 / 25), used for the reciprocal divide by 25.
    localparam logic [27:0] DIV25_RECIP = 28'd171798691;
    localparam logic [5:0] DIV25 = 6'd25;

    // Load enables of the three coordinate scaling stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

`default_nettype wire

/* hw/rtl/gtsp_coord_scale.sv */
// Three-stage pipeline that computes (mag*6 + 50) / 100 for one coordinate.
`default_nettype none

module gtsp_coord_scale (
    input  wire logic                i_clk,
    input  wire gtsp_pkg::t_stage_en i_en,
    input  wire logic [31:0]         i_mag,
    output logic [26:0]              o_q
);

    // (6m + 50) / 100 == ((3m + 25) >> 1) / 25
    logic [33:0] w_sum;
    logic [31:0] r_u;
    logic [31:0] r_u2;
    logic [59:0] w_prod;
    logic [27:0] r_qest;
    logic [32:0] w_q25;
    logic [32:0] w_rem;
    logic        w_fix;

    assign w_sum = ({2'b0, i_mag} << 1) + {2'b0, i_mag} + 34'd25;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_u <= w_sum[32:1];
        end
    end

    // Estimate is the true quotient or one below it.
    assign w_prod = {28'b0, r_u} * {32'b0, gtsp_pkg::DIV25_RECIP};

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_qest <= w_prod[59:32];
            r_u2   <= r_u;
        end
    end

    assign w_q25 = ({5'b0, r_qest} << 4) + ({5'b0, r_qest} << 3) + {5'b0, r_qest};
    assign w_rem = {1'b0, r_u2} - w_q25;
    assign w_fix = (w_rem[5:0] >= gtsp_pkg::DIV25);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            o_q <= r_qest[26:0] + 27'(w_fix);
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/gps_telemetry_slot_packer.sv */
// Top level: GPS report to eight telemetry slot words.
// Word 0 passes a 4-stage pipeline and then the output serializer register.
// The output gives one slot word per cycle while i_m_tready is high, eight words
//   per report; the output serializer emitting them sets the report rate.
// A new report is taken while the previous one drains, so the output runs gapless.
// Reset (synchronous, active low) empties the pipeline and sets base_slot to 1.
`default_nettype none

module gps_telemetry_slot_packer (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input report stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata from bit 0: hours[4:0], minutes[10:5], seconds[16:11], latitude[47:17],
    // longitude[79:48], altitude_dm[96:80], ground_speed[112:97], climb_rate[128:113],
    // zero pad [135:129]
    input  wire logic [135:0] i_s_tdata,
    // slot word stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tdata from bit 0: slot_index[5:0], first_byte[13:6], second_byte[21:14], pad [23:22]
    output logic [23:0]       o_m_tdata,
    // tuser: slot_valid[0]
    output logic              o_m_tuser,
    output logic              o_m_tlast,
    // configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef struct packed {
        logic [16:0] utc;
        logic [9:0]  spd;
        logic [12:0] alt;
        logic [12:0] vspd;
        logic        lat_neg;
        logic        lon_neg;
    } t_misc;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [4:0] r_base_slot;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_slot <= gtsp_pkg::BASE_SLOT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == gtsp_pkg::REG_BASE_SLOT) begin
            r_base_slot <= pwdata[4:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == gtsp_pkg::REG_BASE_SLOT) begin
            prdata = {27'b0, r_base_slot};
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: unpack, take magnitudes, time of day and range checks
    // ------------------------------------------------------------------
    logic [4:0]         w_hours;
    logic [5:0]         w_minutes;
    logic [5:0]         w_seconds;
    logic signed [30:0] w_lat;
    logic signed [31:0] w_lon;
    logic signed [16:0] w_alt;
    logic [15:0]        w_gspd;
    logic signed [15:0] w_climb;
    logic signed [17:0] w_alt_sum;
    logic signed [16:0] w_climb_sum;
    t_misc              w_m0;
    logic [31:0]        w_lat_mag;
    logic [31:0]        w_lon_mag;

    assign w_hours   = i_s_tdata[4:0];
    assign w_minutes = i_s_tdata[10:5];
    assign w_seconds = i_s_tdata[16:11];
    assign w_lat     = i_s_tdata[47:17];
    assign w_lon     = i_s_tdata[79:48];
    assign w_alt     = i_s_tdata[96:80];
    assign w_gspd    = i_s_tdata[112:97];
    assign w_climb   = i_s_tdata[128:113];

    assign w_alt_sum   = {w_alt[16], w_alt} + 18'sd8204;
    assign w_climb_sum = {w_climb[15], w_climb} + 17'sd1500;

    always_comb begin
        w_m0.utc = 17'(w_hours) * 17'd3600 + 17'(w_minutes) * 17'd60 + 17'(w_seconds);
        // Out-of-range values send zero; valid speed and climb rate carry their enable bit.
        w_m0.spd = (w_gspd < 16'd512) ? {1'b1, w_gspd[8:0]} : 10'd0;
        w_m0.alt = (w_alt >= -17'sd8200 && w_alt <= 17'sd48300) ? w_alt_sum[15:3] : 13'd0;
        w_m0.vspd = (w_climb >= -16'sd1500 && w_climb <= 16'sd2600)
                  ? (w_climb_sum[12:0] | 13'h1000) : 13'd0;
        // Zero counts as south / west.
        w_m0.lat_neg = w_lat[30] || (w_lat == 31'sd0);
        w_m0.lon_neg = w_lon[31] || (w_lon == 32'sd0);
        // Negate at 32 bits so the most negative latitude keeps its magnitude.
        w_lat_mag = w_lat[30] ? (~{w_lat[30], w_lat} + 32'd1) : {1'b0, w_lat};
        w_lon_mag = w_lon[31] ? (~w_lon + 32'd1) : w_lon;
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when empty or when its successor loads
    // ------------------------------------------------------------------
    logic r_v0, r_v1, r_v2, r_v3;
    logic w_adv0, w_adv1, w_adv2, w_adv3;
    logic w_ser_ready;
    gtsp_pkg::t_stage_en w_en;

    assign w_adv3 = !r_v3 || w_ser_ready;
    assign w_adv2 = !r_v2 || w_adv3;
    assign w_adv1 = !r_v1 || w_adv2;
    assign w_adv0 = !r_v0 || w_adv1;
    assign o_s_tready = w_adv0;

    assign w_en.s1 = w_adv1;
    assign w_en.s2 = w_adv2;
    assign w_en.s3 = w_adv3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv0) r_v0 <= i_s_tvalid;
            if (w_adv1) r_v1 <= r_v0;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
        end
    end

    t_misc       r_m0, r_m1, r_m2, r_m3;
    logic [31:0] r_lat_mag;
    logic [31:0] r_lon_mag;

    always_ff @(posedge i_clk) begin
        if (w_adv0) begin
            r_m0      <= w_m0;
            r_lat_mag <= w_lat_mag;
            r_lon_mag <= w_lon_mag;
        end
        if (w_adv1) r_m1 <= r_m0;
        if (w_adv2) r_m2 <= r_m1;
        if (w_adv3) r_m3 <= r_m2;
    end

    // ------------------------------------------------------------------
    // Stages 1..3: rescale both coordinates to 1/600000 degree
    // ------------------------------------------------------------------
    logic [26:0] w_lat_q;
    logic [26:0] w_lon_q;

    gtsp_coord_scale u_lat_scale (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (r_lat_mag),
        .o_q   (w_lat_q)
    );

    gtsp_coord_scale u_lon_scale (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (r_lon_mag),
        .o_q   (w_lon_q)
    );

    // ------------------------------------------------------------------
    // Bit-pack into eight two-byte words
    // ------------------------------------------------------------------
    logic [26:0] w_lat_f;
    logic [27:0] w_lon_f;
    logic [7:0]  w_b0 [8];
    logic [7:0]  w_b1 [8];

    assign w_lat_f = w_lat_q | {r_m3.lat_neg, 26'b0};
    assign w_lon_f = {r_m3.lon_neg, w_lon_q};

    always_comb begin
        w_b0[0] = r_m3.utc[7:0];
        w_b1[0] = r_m3.utc[15:8];
        w_b0[1] = {w_lat_f[6:0], r_m3.utc[16]};
        w_b1[1] = w_lat_f[14:7];
        w_b0[2] = w_lat_f[22:15];
        w_b1[2] = {w_lon_f[3:0], w_lat_f[26:23]};
        w_b0[3] = w_lon_f[11:4];
        w_b1[3] = w_lon_f[19:12];
        w_b0[4] = w_lon_f[27:20];
        w_b1[4] = r_m3.spd[7:0];
        w_b0[5] = {6'b0, r_m3.spd[9:8]};
        w_b1[5] = 8'd0;
        w_b0[6] = {r_m3.alt[1:0], 6'b0};
        w_b1[6] = r_m3.alt[9:2];
        w_b0[7] = {r_m3.vspd[4:0], r_m3.alt[12:10]};
        w_b1[7] = r_m3.vspd[12:5];
    end

    // ------------------------------------------------------------------
    // Output serializer: hold one report, advance one word per transfer
    // ------------------------------------------------------------------
    logic [15:0] r_words [8];
    logic [2:0]  r_cnt;
    logic        r_sv;
    logic        w_out_xfer;
    logic        w_load;
    logic [5:0]  w_idx;

    assign w_out_xfer  = r_sv && i_m_tready;
    assign w_ser_ready = !r_sv || (i_m_tready && r_cnt == 3'd7);
    assign w_load      = w_ser_ready && r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_cnt <= 3'd0;
        end else if (w_load) begin
            r_sv  <= 1'b1;
            r_cnt <= 3'd0;
        end else if (w_out_xfer) begin
            if (r_cnt == 3'd7) begin
                r_sv <= 1'b0;
            end
            r_cnt <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int k = 0; k < 8; k++) begin
                r_words[k] <= {w_b1[k], w_b0[k]};
            end
        end
    end

    assign w_idx      = {1'b0, r_base_slot} + {3'b0, r_cnt};
    assign o_m_tvalid = r_sv;
    assign o_m_tdata  = {2'b0, r_words[r_cnt], w_idx};
    assign o_m_tuser  = (w_idx != 6'd0) && ({1'b0, w_idx} < 7'(gtsp_pkg::SLOT_COUNT));
    assign o_m_tlast  = (r_cnt == 3'd7);

endmodule

`default_nettype wire

/* hw/rtl/gtsp_checker.sv */
// Port-level checks for the GPS telemetry slot packer, bound to the top level.
`default_nettype none

module gtsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata,
    input wire logic        o_m_tuser,
    input wire logic        o_m_tlast
);

    // Stalled word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // A report never pauses between its words.
    a_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("gap inside a report");

    // Slot index steps by one inside a report.
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=>
            o_m_tdata[5:0] == 6'($past(o_m_tdata[5:0]) + 6'd1))
        else $error("slot index did not advance");

    // Slot flag follows the slot filter.
    a_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser ==
            ((o_m_tdata[5:0] != 6'd0) && ({1'b0, o_m_tdata[5:0]} < 7'(gtsp_pkg::SLOT_COUNT))))
        else $error("slot flag mismatch");

endmodule

bind gps_telemetry_slot_packer gtsp_checker u_gtsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

/* tb/gps_telemetry_slot_packer_tb.sv */
// Self-checking testbench for the GPS telemetry slot packer.
`default_nettype none

module gps_telemetry_slot_packer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SLOT_COUNT         = 32;
    localparam logic [4:0]  BASE_SLOT_AT_RESET = 5'd1;
    localparam logic [2:0]  BASE_SLOT_ADDR     = {gtsp_pkg::REG_BASE_SLOT, 2'b00};
    localparam logic [31:0] SOUTH_FLAG         = 32'h0400_0000;
    localparam logic [31:0] WEST_FLAG          = 32'h0800_0000;
    localparam int          LONG_STALL         = 300;
    localparam int          TAIL_CYCLES        = 16;
    localparam int          CYCLE_LIMIT        = 200000;
    localparam int          PHASE_REPORTS      = 32;

    // One report as it sits in s_tdata[128:0]; the last member is the lowest field.
    typedef struct packed {
        logic [15:0] climb_rate;
        logic [15:0] ground_speed;
        logic [16:0] altitude_dm;
        logic [31:0] longitude;
        logic [30:0] latitude;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
    } t_gps_report;

    typedef struct packed {
        logic       last_word;
        logic       slot_valid;
        logic [7:0] second_byte;
        logic [7:0] first_byte;
        logic [5:0] slot_index;
    } t_slot_word;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [135:0] s_tdata  = '0;
    logic         m_tready = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    wire logic        o_s_tready;
    wire logic        o_m_tvalid;
    wire logic [23:0] o_m_tdata;
    wire logic        o_m_tuser;
    wire logic        o_m_tlast;
    wire logic [31:0] prdata;
    wire logic        pready;

    t_gps_report pending_reports[$];
    t_slot_word  slot_words_due[$];
    logic [4:0]  base_slot_now  = BASE_SLOT_AT_RESET;
    bit          in_xfer        = 1'b0;
    bit          out_xfer       = 1'b0;
    bit          send_no_gap    = 1'b0;
    bit          recv_no_gap    = 1'b0;
    int          send_gap       = 0;
    int          recv_wait      = 0;
    int          stall_req      = 0;
    int          stall_seen     = 0;
    int          stall_left     = 0;
    int          reports_queued = 0;
    int          reports_taken  = 0;
    int          mismatch_cnt   = 0;
    int          cycle_cnt      = 0;

    gps_telemetry_slot_packer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 i_clk = ~i_clk;

    // Rescale 1e-7 degree to 1/600000 degree with rounding; zero or below gets the flag.
    function automatic logic [31:0] scale_angle(longint deg7, logic [31:0] hemi);
        longint      mag;
        logic [31:0] v;
        mag = (deg7 < 0) ? -deg7 : deg7;
        v = 32'((mag * 6 + 50) / 100);
        return (deg7 <= 0) ? (v | hemi) : v;
    endfunction

    // Work out the eight slot words of one report and queue them in order.
    function automatic void encode_report(t_gps_report r, logic [4:0] base);
        logic [16:0] tod;
        logic [31:0] lat_s, lon_s;
        logic [15:0] alt_s, spd_s, vsi_s;
        logic [7:0]  lo_b [8];
        logic [7:0]  hi_b [8];
        int          alt_dm, climb;
        logic [5:0]  idx;
        t_slot_word  w;
        tod    = 17'(int'(r.hours) * 3600 + int'(r.minutes) * 60 + int'(r.seconds));
        lat_s  = scale_angle($signed(r.latitude), SOUTH_FLAG);
        lon_s  = scale_angle($signed(r.longitude), WEST_FLAG);
        alt_dm = $signed(r.altitude_dm);
        climb  = $signed(r.climb_rate);
        alt_s  = (alt_dm >= -8200 && alt_dm <= 48300) ? 16'((alt_dm + 8204) >>> 3) : 16'd0;
        spd_s  = (r.ground_speed < 16'd512) ? (r.ground_speed | 16'h0200) : 16'd0;
        vsi_s  = (climb >= -1500 && climb <= 2600) ? (16'(climb + 1500) | 16'h1000) : 16'd0;

        // Bit-pack the fields across the eight words, low byte first.
        lo_b[0] = tod[7:0];                  hi_b[0] = tod[15:8];
        lo_b[1] = {lat_s[6:0], tod[16]};     hi_b[1] = lat_s[14:7];
        lo_b[2] = lat_s[22:15];              hi_b[2] = {lon_s[3:0], lat_s[26:23]};
        lo_b[3] = lon_s[11:4];               hi_b[3] = lon_s[19:12];
        lo_b[4] = lon_s[27:20];              hi_b[4] = spd_s[7:0];
        lo_b[5] = {6'd0, spd_s[9:8]};        hi_b[5] = 8'd0;
        lo_b[6] = {alt_s[1:0], 6'd0};        hi_b[6] = alt_s[9:2];
        lo_b[7] = {vsi_s[4:0], alt_s[12:10]}; hi_b[7] = vsi_s[12:5];

        for (int k = 0; k < 8; k++) begin
            idx = {1'b0, base} + 6'(k);
            w.slot_index  = idx;
            w.first_byte  = lo_b[k];
            w.second_byte = hi_b[k];
            w.slot_valid  = (idx != 6'd0) && (int'(idx) < SLOT_COUNT);
            w.last_word   = (k == 7);
            slot_words_due.push_back(w);
        end
    endfunction

    function automatic int draw_gap(bit no_gap);
        return no_gap ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic t_gps_report make_report(int h, int m, int s, longint lat,
                                                longint lon, int alt, int spd, int clb);
        t_gps_report r;
        r.hours        = 5'(h);
        r.minutes      = 6'(m);
        r.seconds      = 6'(s);
        r.latitude     = 31'(lat);
        r.longitude    = 32'(lon);
        r.altitude_dm  = 17'(alt);
        r.ground_speed = 16'(spd);
        r.climb_rate   = 16'(clb);
        return r;
    endfunction

    // Half are well-formed reports with random content; the rest is raw noise or well-formed
    // with one field drawn wide: speed or climb rate over its whole width, altitude wider.
    function automatic t_gps_report random_report();
        logic [159:0] noise;
        int unsigned  pick;
        int           alt, spd, clb;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
        pick  = $urandom_range(0, 9);
        if (pick < 2)
            return noise[128:0];
        alt = (pick == 2) ? int'($urandom_range(0, 81919)) - 16384
                          : int'($urandom_range(0, 56500)) - 8200;
        spd = (pick == 3) ? int'($urandom_range(0, 65535)) : int'($urandom_range(0, 511));
        clb = (pick == 4) ? int'($urandom_range(0, 65535)) - 32768
                          : int'($urandom_range(0, 4100)) - 1500;
        return make_report($urandom_range(0, 24), $urandom_range(0, 60),
                           $urandom_range(0, 60),
                           longint'($urandom_range(0, 1800000000)) - 900000000,
                           longint'($urandom_range(0, 32'd3600000000)) - 1800000000,
                           alt, spd, clb);
    endfunction

    function automatic void queue_report(t_gps_report r);
        pending_reports.push_back(r);
        reports_queued++;
    endfunction

    // Sender: hold tvalid until the transfer, then draw a gap before the next report.
    always @(negedge i_clk) begin : drive_reports
        int gap;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!(s_tvalid && !in_xfer)) begin
            gap = s_tvalid ? draw_gap(send_no_gap) : send_gap;
            if (gap == 0 && pending_reports.size() != 0) begin
                s_tdata  <= {7'd0, pending_reports.pop_front()};
                s_tvalid <= 1'b1;
                send_gap <= 0;
            end else begin
                s_tvalid <= 1'b0;
                send_gap <= (gap == 0) ? 0 : gap - 1;
            end
        end
    end

    // Receiver: a fresh stall request drops tready for a long stretch; otherwise
    // draw a wait after every transfer.
    always @(negedge i_clk) begin : accept_words
        int wait_n;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            recv_wait  <= 0;
            stall_left <= 0;
        end else if (stall_seen != stall_req) begin
            stall_seen <= stall_req;
            stall_left <= LONG_STALL;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!(m_tready && !out_xfer)) begin
            wait_n = m_tready ? draw_gap(recv_no_gap) : recv_wait;
            if (wait_n == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready  <= 1'b0;
                recv_wait <= wait_n - 1;
            end
        end
    end

    // Track the register, predict on each input transfer, check each output transfer.
    always @(posedge i_clk) begin : score_words
        t_slot_word seen, due;
        in_xfer  <= i_rst_n && s_tvalid && o_s_tready;
        out_xfer <= i_rst_n && o_m_tvalid && m_tready;
        if (!i_rst_n) begin
            base_slot_now <= BASE_SLOT_AT_RESET;
        end else begin
            if (psel && penable && pwrite && pready && paddr == BASE_SLOT_ADDR)
                base_slot_now <= pwdata[4:0];
            if (s_tvalid && o_s_tready) begin
                encode_report(s_tdata[128:0], base_slot_now);
                reports_taken++;
            end
            if (o_m_tvalid && m_tready) begin
                seen.slot_index  = o_m_tdata[5:0];
                seen.first_byte  = o_m_tdata[13:6];
                seen.second_byte = o_m_tdata[21:14];
                seen.slot_valid  = o_m_tuser;
                seen.last_word   = o_m_tlast;
                if (slot_words_due.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("%0t: unexpected slot word idx=%0d b0=%02h b1=%02h",
                                 $realtime, seen.slot_index, seen.first_byte,
                                 seen.second_byte);
                    mismatch_cnt++;
                end else begin
                    due = slot_words_due.pop_front();
                    if (seen !== due) begin
                        if (mismatch_cnt < 10) begin
                            $display("%0t: slot word exp idx=%0d b0=%02h b1=%02h valid=%0b last=%0b",
                                     $realtime, due.slot_index, due.first_byte,
                                     due.second_byte, due.slot_valid, due.last_word);
                            $display("%0t: slot word got idx=%0d b0=%02h b1=%02h valid=%0b last=%0b",
                                     $realtime, seen.slot_index, seen.first_byte,
                                     seen.second_byte, seen.slot_valid, seen.last_word);
                        end
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Wait until every report has been taken and every slot word has come back.
    task automatic wait_idle();
        while (reports_taken != reports_queued || slot_words_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Register write in a setup and an access phase; upper data bits carry noise that the block must drop.
    task automatic write_base(logic [4:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_SLOT_ADDR;
        pwdata  <= {27'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : run_phases
        logic [4:0] bases [7];
        bases = '{5'd0, 5'd31, 5'd24, 5'd7, 5'd30, 5'd1, 5'($urandom_range(0, 31))};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed reports at the reset base: field extremes, hemisphere on zero,
        // coordinate rounding edges, and each range check on both sides of its bound.
        @(posedge i_clk);
        queue_report(make_report(0, 0, 0, 0, 0, 0, 0, 0));
        queue_report(make_report(31, 63, 63, -1, -1, -1, 65535, -1));
        queue_report(make_report(24, 60, 60, 900000000, 1800000000, 48300, 511, 2600));
        queue_report(make_report(23, 59, 59, -900000000, -1800000000, -8200, 512, -1500));
        queue_report(make_report(12, 30, 0, -1073741824, -2147483648, 48301, 0, 2601));
        queue_report(make_report(1, 1, 1, 1073741823, 2147483647, -8201, 1, -1501));
        queue_report(make_report(0, 0, 1, 8, 9, -16384, 65535, -32768));
        queue_report(make_report(5, 6, 7, 75, -75, 65535, 100, 32767));
        queue_report(make_report(17, 45, 30, -9, 1, -65536, 300, 0));
        queue_report(make_report(0, 59, 60, 1, -1, 8, 2, 1));
        queue_report(make_report(22, 0, 0, 123456789, -98765432, 0, 511, -1));
        wait_idle();

        // Random phases, each at a new base slot; the sender pauses at every boundary.
        for (int p = 0; p < 7; p++) begin
            write_base(bases[p]);
            @(posedge i_clk);
            send_no_gap = (p == 1) || (p == 3);
            recv_no_gap = (p == 3);
            // Hold off the receiver while the sender streams, so the block backs up.
            if (p == 1)
                stall_req++;
            for (int n = 0; n < PHASE_REPORTS; n++)
                queue_report(random_report());
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (slot_words_due.size() != 0)
            $display("slot words never received: %0d", slot_words_due.size());
        if (mismatch_cnt == 0 && slot_words_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
